// ----- rtl/cmap_pkg.sv -----
// shared types, widths and codes of the colormap lookup block
package cmap_pkg;

   localparam int DEFAULT_TABLE_DEPTH   = 256;
   localparam int DEFAULT_FRACTION_BITS = 8;

   localparam int SAMPLE_W = 17;
   localparam int RECIP_W  = 24;
   localparam int COUNT_W  = 9;
   localparam int SLOT_W   = 8;
   localparam int CHAN_W   = 8;
   localparam int POS_W    = 17;
   localparam int CSR_W    = 24;
   localparam int PROD_W   = SAMPLE_W + RECIP_W;
   localparam int PROD_SH  = 8;

   localparam logic [POS_W-1:0]   POS_ONE        = POS_W'(65536);
   localparam logic [RECIP_W-1:0] RECIP_RESET    = RECIP_W'(256);
   localparam logic [COUNT_W-1:0] COUNT_RESET    = COUNT_W'(256);

   typedef enum logic [1:0] {
      CSR_LOWER_BOUND = 2'd0,
      CSR_RECIP_RANGE = 2'd1,
      CSR_ENTRY_COUNT = 2'd2,
      CSR_LINEAR_MODE = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_CONVERT = 1'b0,
      OP_LOAD    = 1'b1
   } op_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic              load;
      logic              null_px;
      logic [SLOT_W-1:0] slot;
      rgb_type           colour;
   } item_type;

endpackage

// ----- rtl/index_to_rgb_colormap.sv -----
// top level: pixel sample to rgb colour through a loadable colour table
//
// the req channel carries one transaction per pixel or per table load;
// opcode selects convert or load. a load writes one table entry and gives
// no rsp transaction; a convert gives exactly one rsp transaction, in order.
// csr writes set the lower bound, recip_range, entry_count and linear_mode;
// they are to be made only while no transaction is in flight, which the
// block itself does not enforce; csr_ready is always high.
// the datapath is six register stages: offset, range multiply, saturate,
// entry count multiply, table read, blend. one transaction is taken every
// cycle while rsp is not stalled, set by the single pass through each stage
// and the two read ports of the table. a load writes the table at the read
// stage, so later pixels see it and earlier ones do not.
// reset (synchronous) empties the pipeline and restores the csr reset
// values; the table holds no defined content until loaded.
// when rsp_ready is low the pipeline fills its empty stages and then drops
// req_ready; nothing is lost or repeated.
module index_to_rgb_colormap #(
   parameter int TABLE_DEPTH   = cmap_pkg::DEFAULT_TABLE_DEPTH,
   parameter int FRACTION_BITS = cmap_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic signed [cmap_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               req_sample_is_null,
   input  logic [cmap_pkg::SLOT_W-1:0]        req_entry_slot,
   input  logic [cmap_pkg::CHAN_W-1:0]        req_entry_red,
   input  logic [cmap_pkg::CHAN_W-1:0]        req_entry_green,
   input  logic [cmap_pkg::CHAN_W-1:0]        req_entry_blue,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cmap_pkg::CHAN_W-1:0]        rsp_red,
   output logic [cmap_pkg::CHAN_W-1:0]        rsp_green,
   output logic [cmap_pkg::CHAN_W-1:0]        rsp_blue,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [cmap_pkg::CSR_W-1:0]         csr_data
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int N_W    = $clog2(TABLE_DEPTH + 1);
   localparam int SC_W   = cmap_pkg::POS_W + N_W;
   localparam int SH_W   = cmap_pkg::PROD_W - cmap_pkg::PROD_SH;
   localparam int FB     = FRACTION_BITS;
   localparam int BL_W   = cmap_pkg::CHAN_W + FB + 1;
   localparam logic [SC_W-1:0] HALF = SC_W'(32768);

   function automatic logic [N_W-1:0] clamp_count(input logic [cmap_pkg::COUNT_W-1:0] c);
      logic [N_W-1:0] r;
      if (c == '0) begin
         r = N_W'(1);
      end else if (32'(c) > 32'(TABLE_DEPTH)) begin
         r = N_W'(TABLE_DEPTH);
      end else begin
         r = N_W'(c);
      end
      return r;
   endfunction

   function automatic logic [cmap_pkg::CHAN_W-1:0] blend(
      input logic [cmap_pkg::CHAN_W-1:0] c0,
      input logic [cmap_pkg::CHAN_W-1:0] c1,
      input logic [FB-1:0]               f
   );
      logic [FB:0]     w0;
      logic [BL_W-1:0] v;
      w0 = (FB+1)'(1) << FB;
      w0 = w0 - (FB+1)'(f);
      v  = BL_W'(c0) * BL_W'(w0) + BL_W'(c1) * BL_W'(f);
      return v[FB +: cmap_pkg::CHAN_W];
   endfunction

   // configuration
   logic signed [cmap_pkg::SAMPLE_W-1:0] lower_bound_ff;
   logic [cmap_pkg::RECIP_W-1:0]         recip_range_ff;
   logic [N_W-1:0]                       count_ff;
   logic                                 linear_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_bound_ff <= '0;
         recip_range_ff <= cmap_pkg::RECIP_RESET;
         count_ff       <= clamp_count(cmap_pkg::COUNT_RESET);
         linear_ff      <= 1'b0;
      end else if (csr_valid) begin
         case (cmap_pkg::csr_index_type'(csr_index))
            cmap_pkg::CSR_LOWER_BOUND: begin
               lower_bound_ff <= $signed(csr_data[cmap_pkg::SAMPLE_W-1:0]);
            end
            cmap_pkg::CSR_RECIP_RANGE: begin
               recip_range_ff <= csr_data[cmap_pkg::RECIP_W-1:0];
            end
            cmap_pkg::CSR_ENTRY_COUNT: begin
               count_ff <= clamp_count(csr_data[cmap_pkg::COUNT_W-1:0]);
            end
            cmap_pkg::CSR_LINEAR_MODE: begin
               linear_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage enables
   logic en1, en2, en3, en4, en5, en6;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic rsp_valid_ff;

   assign en6       = !rsp_valid_ff || rsp_ready;
   assign en5       = !s5_valid_ff || en6;
   assign en4       = !s4_valid_ff || en5;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   // stage 1: offset from minimum
   cmap_pkg::item_type               s1_item_in, s1_item_ff;
   logic signed [cmap_pkg::SAMPLE_W:0] diff;
   logic [cmap_pkg::SAMPLE_W-1:0]    s1_diff_in, s1_diff_ff;

   always_comb begin
      s1_item_in.load         = (cmap_pkg::op_type'(req_opcode) == cmap_pkg::OP_LOAD);
      s1_item_in.null_px      = req_sample_is_null;
      s1_item_in.slot         = req_entry_slot;
      s1_item_in.colour.red   = req_entry_red;
      s1_item_in.colour.green = req_entry_green;
      s1_item_in.colour.blue  = req_entry_blue;
      diff = (cmap_pkg::SAMPLE_W+1)'(req_sample) - (cmap_pkg::SAMPLE_W+1)'(lower_bound_ff);
      if (diff[cmap_pkg::SAMPLE_W] || diff == '0) begin
         s1_diff_in = '0;
      end else begin
         s1_diff_in = diff[cmap_pkg::SAMPLE_W-1:0];
      end
   end

   // stage 2: times reciprocal range
   cmap_pkg::item_type          s2_item_ff;
   logic [cmap_pkg::PROD_W-1:0] s2_prod;
   logic [SH_W-1:0]             s2_prod_ff;

   assign s2_prod = cmap_pkg::PROD_W'(s1_diff_ff) * cmap_pkg::PROD_W'(recip_range_ff);

   // stage 3: saturate to one
   cmap_pkg::item_type         s3_item_ff;
   logic [cmap_pkg::POS_W-1:0] s3_pos_in, s3_pos_ff;

   always_comb begin
      if (s2_prod_ff > SH_W'(cmap_pkg::POS_ONE)) begin
         s3_pos_in = cmap_pkg::POS_ONE;
      end else begin
         s3_pos_in = s2_prod_ff[cmap_pkg::POS_W-1:0];
      end
   end

   // stage 4: times entry count
   cmap_pkg::item_type s4_item_ff;
   logic [SC_W-1:0]    s4_scaled_ff;

   // stage 5: index, fraction and table read
   logic [SC_W-1:0]  rounded;
   logic [N_W-1:0]   raw_idx, n_m1, i0, i1;
   logic [FB-1:0]    s5_frac_in, s5_frac_ff;
   logic             s5_null_ff;
   logic             tbl_wr_en;
   cmap_pkg::rgb_type e0, e1;

   always_comb begin
      n_m1    = count_ff - N_W'(1);
      rounded = s4_scaled_ff + HALF;
      if (linear_ff) begin
         raw_idx    = s4_scaled_ff[16 +: N_W];
         s5_frac_in = s4_scaled_ff[16-FB +: FB];
      end else begin
         raw_idx    = rounded[16 +: N_W];
         s5_frac_in = '0;
      end
      i0 = (raw_idx > n_m1) ? n_m1 : raw_idx;
      i1 = (i0 == n_m1) ? i0 : i0 + N_W'(1);
   end

   assign tbl_wr_en = en5 && s4_valid_ff && s4_item_ff.load &&
                      (32'(s4_item_ff.slot) < 32'(TABLE_DEPTH));

   cmap_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_wr_en),
      .wr_addr  (IDX_W'(s4_item_ff.slot)),
      .wr_data  (s4_item_ff.colour),
      .rd_en    (en5),
      .rd_addr0 (IDX_W'(i0)),
      .rd_addr1 (IDX_W'(i1)),
      .rd_data0 (e0),
      .rd_data1 (e1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (en4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (en5) begin
            s5_valid_ff <= s4_valid_ff && !s4_item_ff.load;
         end
         if (en6) begin
            rsp_valid_ff <= s5_valid_ff;
         end
      end
   end

   // stage 6: blend into output register, or black for a null pixel
   logic [cmap_pkg::CHAN_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_item_ff <= s1_item_in;
         s1_diff_ff <= s1_diff_in;
      end
      if (en2) begin
         s2_item_ff <= s1_item_ff;
         s2_prod_ff <= s2_prod[cmap_pkg::PROD_SH +: SH_W];
      end
      if (en3) begin
         s3_item_ff <= s2_item_ff;
         s3_pos_ff  <= s3_pos_in;
      end
      if (en4) begin
         s4_item_ff   <= s3_item_ff;
         s4_scaled_ff <= SC_W'(s3_pos_ff) * SC_W'(count_ff);
      end
      if (en5) begin
         s5_null_ff <= s4_item_ff.null_px;
         s5_frac_ff <= s5_frac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!en6) begin
      end else if (s5_null_ff) begin
         rsp_red_ff   <= '0;
         rsp_green_ff <= '0;
         rsp_blue_ff  <= '0;
      end else begin
         rsp_red_ff   <= blend(e0.red,   e1.red,   s5_frac_ff);
         rsp_green_ff <= blend(e0.green, e1.green, s5_frac_ff);
         rsp_blue_ff  <= blend(e0.blue,  e1.blue,  s5_frac_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

// ----- rtl/cmap_table.sv -----
// colour table memory, one write port and two registered read ports
module cmap_table #(
   parameter int TABLE_DEPTH = cmap_pkg::DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  cmap_pkg::rgb_type  wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr0,
   input  logic [IDX_W-1:0]   rd_addr1,
   output cmap_pkg::rgb_type  rd_data0,
   output cmap_pkg::rgb_type  rd_data1
);

   cmap_pkg::rgb_type mem [TABLE_DEPTH];
   cmap_pkg::rgb_type rd0_ff;
   cmap_pkg::rgb_type rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule
